@@ design/hbp_pkg.sv @@
// Shared types and constants for the prefix-code bit packer.
package hbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;
    localparam int SYM_W        = 8;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int BYTE_W       = 8;
    // pending bits (at most 7) plus one full code word
    localparam int ACC_W        = CODE_W + BYTE_W - 1;
    localparam int TOT_W        = 6;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_word;
        logic [LEN_W-1:0]  code_length;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [2:0]        pad_bits;
        logic              last;
    } t_out_item;

    // one code table entry
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_entry;

    // command passed from front to back
    typedef struct packed {
        logic              is_flush;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_cmd;

endpackage

@@ design/hbp_front.sv @@
// Front end: accepts beats, holds the code table, turns encodes into masked codes, passes flushes on.
module hbp_front
    import hbp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in,
    output logic     o_in_ready,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_full
);

    t_entry            r_mem [SYMBOL_COUNT];
    t_entry            r_rd;
    logic              r_s1_valid;
    logic [1:0]        r_s1_op;

    logic              w_accept;
    logic              w_sym_ok;
    logic              w_stall;
    logic [LEN_W-1:0]  w_len;
    logic [CODE_W:0]   w_mask_full;
    logic [CODE_W-1:0] w_code;

    assign w_sym_ok = ({1'b0, i_in.symbol} < (SYM_W+1)'(SYMBOL_COUNT));

    // saturate the length and drop code bits above it
    assign w_len       = (r_rd.len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : r_rd.len;
    assign w_mask_full = ((CODE_W+1)'(1) << w_len) - (CODE_W+1)'(1);
    assign w_code      = r_rd.code & w_mask_full[CODE_W-1:0];

    always_comb begin
        o_cmd_valid = 1'b0;
        case (r_s1_op)
            OP_ENCODE: o_cmd_valid = r_s1_valid && (w_len != '0);
            OP_FLUSH:  o_cmd_valid = r_s1_valid;
            default:   o_cmd_valid = 1'b0;
        endcase
    end

    assign o_cmd.is_flush = (r_s1_op == OP_FLUSH);
    assign o_cmd.code     = w_code;
    assign o_cmd.len      = w_len;

    assign w_stall    = o_cmd_valid && i_cmd_full;
    assign o_in_ready = !r_s1_valid || !w_stall;
    assign w_accept   = i_in_valid && o_in_ready;

    // stage-one valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (!w_stall) begin
            r_s1_valid <= 1'b0;
        end
    end

    // code table write and registered lookup
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op <= i_in.op;
            r_rd    <= r_mem[i_in.symbol];
            if (i_in.op == OP_LOAD && w_sym_ok) begin
                r_mem[i_in.symbol] <= '{len: i_in.code_length, code: i_in.code_word};
            end
        end
    end

endmodule

@@ design/hbp_queue.sv @@
// Short command queue between front and back.
module hbp_queue
    import hbp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_buf[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= i_cmd;
        end
    end

endmodule

@@ design/hbp_back.sv @@
// Back end: bit accumulator that emits one packed byte per cycle while the output is free.
module hbp_back
    import hbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_out_ready
);

    // bits below r_total in r_acc are pending, the rest is don't-care
    logic [ACC_W-1:0] r_acc;
    logic [TOT_W-1:0] r_total;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             w_free;
    logic             w_emit_enc;
    logic             w_pop_enc;
    logic             w_pop_fl;
    logic             w_emit_fl;
    logic [TOT_W-1:0] w_teff;
    logic [TOT_W-1:0] n_total;
    logic [ACC_W-1:0] n_acc;
    logic [ACC_W-1:0] w_shr;
    logic [ACC_W-1:0] w_shl;

    assign w_free     = !r_out_valid || i_out_ready;
    assign w_emit_enc = (r_total >= TOT_W'(BYTE_W)) && w_free;
    assign w_teff     = w_emit_enc ? (r_total - TOT_W'(BYTE_W)) : r_total;

    // next command may enter once fewer than a byte of bits remains
    assign w_pop_enc = i_cmd_valid && !i_cmd.is_flush && (w_teff < TOT_W'(BYTE_W));
    assign w_pop_fl  = i_cmd_valid && i_cmd.is_flush && (r_total < TOT_W'(BYTE_W)) && w_free;
    assign w_emit_fl = w_pop_fl && (r_total != '0);
    assign o_pop     = w_pop_enc || w_pop_fl;

    assign w_shr = r_acc >> (r_total - TOT_W'(BYTE_W));
    assign w_shl = r_acc << (TOT_W'(BYTE_W) - r_total);

    always_comb begin
        n_acc   = r_acc;
        n_total = w_teff;
        if (w_pop_enc) begin
            n_acc   = (r_acc << i_cmd.len) | ACC_W'(i_cmd.code);
            n_total = w_teff + i_cmd.len;
        end else if (w_pop_fl) begin
            n_total = '0;
        end
    end

    // accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else begin
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_enc || w_emit_fl) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_enc) begin
            r_out.out_byte <= w_shr[BYTE_W-1:0];
            r_out.pad_bits <= '0;
            r_out.last     <= (w_teff < TOT_W'(BYTE_W));
        end else if (w_emit_fl) begin
            r_out.out_byte <= w_shl[BYTE_W-1:0];
            r_out.pad_bits <= 3'(TOT_W'(BYTE_W) - r_total);
            r_out.last     <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ design/huffman_bit_packer_core.sv @@
// An encode passes the lookup register, the command queue and the bit accumulator to the
// output register; a flush passes the lookup register and the queue, then the output register.
// Throughput: one input beat per cycle while the queue has room; an encode yields one byte
// per cycle while the output is ready, set by the byte-wide output. Loads, zero-length codes
// and empty flushes yield nothing. Reset (synchronous, active low) clears the pending bits,
// queue and output valid; the code table is not cleared and must be loaded before use.
module huffman_bit_packer_core
    import hbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_out_ready
);

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_full;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_pop;

    hbp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_ready  (o_in_ready),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_full  (w_full)
    );

    hbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_valid),
        .i_cmd   (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    hbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_ready (i_out_ready)
    );

endmodule

@@ design/hbp_checker.sv @@
// Port-level checks for the bit packer, bound to the top level.
module hbp_checker
    import hbp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input t_out_item o_out,
    input logic      i_out_ready
);

    // a stalled output beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // and keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out))
        else $error("output payload changed while stalled");

    // padded bytes only come from a flush, which always closes the item
    a_pad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.pad_bits != 3'd0) |-> o_out.last)
        else $error("padded byte not marked last");

    // padding bits are zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.pad_bits != 3'd0) |->
            (8'(o_out.out_byte << (3'd0 - o_out.pad_bits)) == 8'd0))
        else $error("nonzero padding bits");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind huffman_bit_packer_core hbp_checker u_hbp_checker (.*);

@@ test/huffman_bit_packer_core_tb.sv @@
// Self-checking testbench for the prefix-code bit packer: table loads, encodes, flushes.
module huffman_bit_packer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hbp_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         PHASES      = 5;
    localparam int         PHASE_BEATS = 70;

    // Tracks the code table and pending bits; holds the bytes still owed by the block.
    class bit_stream_model;
        t_entry    code_table [SYMBOL_COUNT];
        logic [6:0] pend_bits;
        logic [2:0] pend_count;
        t_out_item due_bytes [$];
        int        bad_bytes;

        function new();
            pend_bits  = '0;
            pend_count = '0;
            bad_bytes  = 0;
        endfunction

        // Work out the bytes an accepted input beat produces
        function void note_beat(t_in_item it);
            t_entry     ent;
            int         len;
            int         total;
            logic [63:0] acc;
            logic [63:0] code;
            t_out_item  b;
            case (it.op)
                OP_LOAD: begin
                    if (it.symbol < SYMBOL_COUNT) begin
                        ent.len  = it.code_length;
                        ent.code = it.code_word;
                        code_table[it.symbol] = ent;
                    end
                end
                OP_ENCODE: begin
                    if (it.symbol >= SYMBOL_COUNT) return;
                    ent = code_table[it.symbol];
                    len = ent.len;
                    if (len > MAX_CODE_LEN) len = MAX_CODE_LEN;
                    if (len == 0) return;
                    code  = 64'(ent.code) & ((64'd1 << len) - 64'd1);
                    acc   = (64'(pend_bits) << len) | code;
                    total = pend_count + len;
                    // emit whole bytes, oldest bits first
                    while (total >= 8) begin
                        b.out_byte = 8'(acc >> (total - 8));
                        total      = total - 8;
                        b.pad_bits = '0;
                        b.last     = (total < 8);
                        due_bytes.push_back(b);
                    end
                    pend_count = 3'(total);
                    pend_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
                end
                OP_FLUSH: begin
                    if (pend_count == 0) return;
                    b.out_byte = 8'({1'b0, pend_bits} << (8 - pend_count));
                    b.pad_bits = 3'(8 - pend_count);
                    b.last     = 1'b1;
                    due_bytes.push_back(b);
                    pend_bits  = '0;
                    pend_count = '0;
                end
                default: begin
                    // unused op: no effect
                end
            endcase
        endfunction

        // Compare one output beat with the oldest owed byte
        function void check_byte(t_out_item got);
            t_out_item exp;
            if (due_bytes.size() == 0) begin
                $display("%0t unexpected byte: got byte %h pad %0d last %0d",
                         $time, got.out_byte, got.pad_bits, got.last);
                bad_bytes++;
                return;
            end
            exp = due_bytes.pop_front();
            if (exp.out_byte !== got.out_byte) begin
                $display("%0t out_byte mismatch: expected %h actual %h",
                         $time, exp.out_byte, got.out_byte);
                bad_bytes++;
            end
            if (exp.pad_bits !== got.pad_bits) begin
                $display("%0t pad_bits mismatch: expected %0d actual %0d",
                         $time, exp.pad_bits, got.pad_bits);
                bad_bytes++;
            end
            if (exp.last !== got.last) begin
                $display("%0t last mismatch: expected %0d actual %0d",
                         $time, exp.last, got.last);
                bad_bytes++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out;
    logic      i_out_ready;

    bit_stream_model stream = new();

    // symbols with a loaded table entry; encodes only pick from these
    bit          loaded [SYMBOL_COUNT];
    byte unsigned loaded_list [$];

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 20;
    bit hold_request = 1'b0;

    huffman_bit_packer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .o_out      (o_out),
        .i_out_ready(i_out_ready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #1_000_000;
        $display("[huffman_bit_packer_core] ERROR");
        $finish;
    end

    function automatic t_in_item make_beat(logic [1:0] op, logic [7:0] sym,
                                           logic [31:0] cw, logic [5:0] cl);
        t_in_item it;
        it.op          = op;
        it.symbol      = sym;
        it.code_word   = cw;
        it.code_length = cl;
        return it;
    endfunction

    // Random beat: mostly encodes of loaded symbols, some loads, flushes and noise
    function automatic t_in_item next_random_beat();
        t_in_item it;
        int       r;
        int       lr;
        it = make_beat(OP_ENCODE, 8'($urandom_range(0, 255)), $urandom,
                       6'($urandom_range(0, 63)));
        r  = $urandom_range(0, 99);
        if (r < 12 || loaded_list.size() == 0) begin
            it.op = OP_LOAD;
            lr    = $urandom_range(0, 19);
            // short codes are favoured; zero and oversize lengths appear now and then
            if (lr == 0)
                it.code_length = '0;
            else if (lr == 1)
                it.code_length = 6'($urandom_range(MAX_CODE_LEN + 1, 63));
            else if (lr < 8)
                it.code_length = 6'($urandom_range(1, 8));
            else
                it.code_length = 6'($urandom_range(1, MAX_CODE_LEN));
        end else if (r < 84) begin
            it.symbol = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        end else if (r < 97) begin
            it.op = OP_FLUSH;
        end else begin
            it.op = OP_UNUSED;
        end
        return it;
    endfunction

    // Offer one beat and hold it until taken; valid stays high afterward
    task automatic send_beat(t_in_item it);
        if (it.op == OP_LOAD && !loaded[it.symbol]) begin
            loaded[it.symbol] = 1'b1;
            loaded_list.push_back(it.symbol);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        stream.note_beat(it);
    endtask

    task automatic sender_pause(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        while (stream.due_bytes.size() != 0) @(posedge i_clk);
    endtask

    // Output side: check taken beats, then pick ready for the next cycle
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                stream.check_byte(o_out);
            if (stall_left > 0) begin
                stall_left--;
            end else if (hold_request) begin
                stall_left   = HOLD_CYCLES;
                hold_request = 1'b0;
            end else if ($urandom_range(0, 99) < rx_idle_pct) begin
                stall_left = $urandom_range(1, 15);
            end
            i_out_ready <= (stall_left == 0);
        end
    end

    // Input side and run control
    initial begin : stimulus
        t_in_item it;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, saturation, zero length, masking, empty flush
        send_beat(make_beat(OP_LOAD, 8'd0,   32'hFFFF_FFFF, 6'd32));
        send_beat(make_beat(OP_LOAD, 8'd255, 32'h0000_0000, 6'd1));
        send_beat(make_beat(OP_LOAD, 8'd1,   32'hA5A5_A5A5, 6'd0));
        send_beat(make_beat(OP_LOAD, 8'd2,   32'h8000_0001, 6'd63));
        send_beat(make_beat(OP_LOAD, 8'd3,   32'hFFFF_FFF5, 6'd3));
        send_beat(make_beat(OP_LOAD, 8'd4,   32'h0000_0001, 6'd33));
        send_beat(make_beat(OP_LOAD, 8'd128, 32'h0000_0000, 6'd32));
        send_beat(make_beat(OP_FLUSH,  8'd0,   32'h0, 6'd0));
        send_beat(make_beat(OP_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63));
        send_beat(make_beat(OP_ENCODE, 8'd255, $urandom, 6'($urandom)));
        send_beat(make_beat(OP_ENCODE, 8'd0,   $urandom, 6'($urandom)));
        send_beat(make_beat(OP_ENCODE, 8'd1,   $urandom, 6'($urandom)));
        send_beat(make_beat(OP_ENCODE, 8'd3,   $urandom, 6'($urandom)));
        send_beat(make_beat(OP_ENCODE, 8'd2,   $urandom, 6'($urandom)));
        send_beat(make_beat(OP_ENCODE, 8'd4,   $urandom, 6'($urandom)));
        send_beat(make_beat(OP_ENCODE, 8'd128, $urandom, 6'($urandom)));
        send_beat(make_beat(OP_FLUSH,  8'd0,   32'h0, 6'd0));
        send_beat(make_beat(OP_FLUSH,  8'd0,   32'h0, 6'd0));
        send_beat(make_beat(OP_ENCODE, 8'd3,   32'h0, 6'd0));
        send_beat(make_beat(OP_ENCODE, 8'd3,   32'h0, 6'd0));
        send_beat(make_beat(OP_ENCODE, 8'd3,   32'h0, 6'd0));
        send_beat(make_beat(OP_FLUSH,  8'd255, 32'hFFFF_FFFF, 6'd63));
        sender_pause(1);
        wait_for_drain();

        // random phases; the last one runs with no idling at all
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin tx_idle_pct = 20; rx_idle_pct = 20; end
                1: begin tx_idle_pct = 0;  rx_idle_pct = 40; end
                2: begin tx_idle_pct = 40; rx_idle_pct = 0;  end
                3: begin tx_idle_pct = 10; rx_idle_pct = 10; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            // long receiver hold while the sender keeps pushing
            if (p == 1)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                it = next_random_beat();
                send_beat(it);
                if ($urandom_range(0, 99) < tx_idle_pct)
                    sender_pause($urandom_range(1, 15));
            end
            if (p < PHASES - 1) begin
                sender_pause(1);
                wait_for_drain();
            end
        end

        i_in_valid <= 1'b0;
        wait_for_drain();
        repeat (10) @(posedge i_clk);
        if (stream.bad_bytes == 0 && stream.due_bytes.size() == 0) begin
            $display("[huffman_bit_packer_core] OK");
        end else begin
            $display("[huffman_bit_packer_core] ERROR");
        end
        $finish;
    end

endmodule

@@ huffman_bit_packer_core.f @@
design/hbp_pkg.sv
design/hbp_front.sv
design/hbp_queue.sv
design/hbp_back.sv
design/huffman_bit_packer_core.sv
design/hbp_checker.sv
test/huffman_bit_packer_core_tb.sv
